// ----- rtl/qee_pkg.sv -----
`timescale 1ns / 1ps

package qee_pkg;

	localparam int TARGET_W = 12;
	localparam int DEN_W    = 16;
	localparam int SMOOTH_W = 9;
	localparam int CFG_W    = 16;

	localparam logic [TARGET_W-1:0] TARGET_NUM     = 12'd3000;
	localparam logic [TARGET_W-1:0] TARGET_AT_ZERO = 12'd4000;
	localparam logic [SMOOTH_W-1:0] SMOOTH_RESET   = 9'd16;
	localparam logic [CFG_W-1:0]    START_RESET    = 16'd4000;

	typedef enum logic [1:0] {
		CMD_STOP = 2'd0,
		CMD_CW   = 2'd1,
		CMD_CCW  = 2'd2
	} cmd_t;

	typedef enum logic {
		CFG_SMOOTH = 1'b0,
		CFG_START  = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_TARGET,
		ST_PREP,
		ST_DIV_RAMP
	} state_t;

	typedef struct packed {
		logic [15:0] duty;
		logic [1:0]  command;
		logic        run;
	} in_t;

	typedef struct packed {
		logic        enc_a;
		logic        enc_b;
		logic        update_event;
		logic        step_valid;
		logic        step_dir;
		logic [15:0] period_now;
	} out_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        step_en;
		logic        step_rev;
		logic        run;
	} item_t;

endpackage

// ----- rtl/qee_front.sv -----
`timescale 1ns / 1ps

module qee_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  qee_pkg::in_t   sample,
	output logic           head_valid,
	output qee_pkg::item_t head,
	input  logic           head_take
);

	qee_pkg::item_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           wr_en;
	qee_pkg::item_t cls;

	// classify the command into step flags
	always_comb begin
		cls.duty     = sample.duty;
		cls.run      = sample.run;
		cls.step_en  = (sample.command == qee_pkg::CMD_CW) ||
			(sample.command == qee_pkg::CMD_CCW);
		cls.step_rev = (sample.command == qee_pkg::CMD_CCW);
	end

	assign full       = (count_q == 2'd2);
	assign wr_en      = push && !full;
	assign head_valid = (count_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en)
				wr_ptr_q <= !wr_ptr_q;
			if (head_take)
				rd_ptr_q <= !rd_ptr_q;
			if (wr_en && !head_take)
				count_q <= count_q + 2'd1;
			else if (!wr_en && head_take)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			ent_q[wr_ptr_q] <= cls;
	end

endmodule

// ----- rtl/qee_div.sv -----
`timescale 1ns / 1ps

module qee_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W:0]   remainder
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic             fits;

	assign shifted   = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign fits      = (shifted >= {1'b0, den_q});
	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? (shifted - {1'b0, den_q}) : shifted;
		end
	end

	a_done_follows_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

endmodule

// ----- rtl/qee_back.sv -----
`timescale 1ns / 1ps

module qee_back #(
	parameter int PERIOD_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       head_valid,
	input  qee_pkg::item_t             head,
	output logic                       head_take,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [qee_pkg::CFG_W-1:0]  cfg_data,
	output logic                       empty,
	input  logic                       pop,
	output qee_pkg::out_t              result
);

	localparam int NUM_W = (PERIOD_BITS > qee_pkg::TARGET_W) ? PERIOD_BITS : qee_pkg::TARGET_W;

	qee_pkg::state_t state_q, state_d;

	logic [qee_pkg::SMOOTH_W-1:0] smooth_q;
	logic [qee_pkg::CFG_W-1:0]    start_q;
	logic [PERIOD_BITS-1:0]       cnt_q;
	logic [PERIOD_BITS-1:0]       period_q;
	logic [1:0]                   pos_q;
	logic                         was_q;
	logic                         res_valid_q;
	qee_pkg::out_t                res_q;
	logic [qee_pkg::TARGET_W-1:0] target_q;
	logic                         neg_q;
	logic                         step_en_q;
	logic                         step_rev_q;

	logic                         take;
	logic                         res_wr;
	logic                         ramp_done;
	logic                         div_start;
	logic [NUM_W-1:0]             div_dividend;
	logic [qee_pkg::DEN_W-1:0]    div_divisor;
	logic                         div_busy;
	logic                         div_done;
	logic [NUM_W-1:0]             div_quo;
	logic [qee_pkg::DEN_W:0]      div_rem;

	logic [PERIOD_BITS-1:0]       period_eff;
	logic [PERIOD_BITS-1:0]       period_take;
	logic                         wrap;
	logic                         upd;
	logic [qee_pkg::SMOOTH_W-1:0] div_eff;
	logic [NUM_W-1:0]             t_ext;
	logic [NUM_W-1:0]             p_ext;
	logic                         neg;
	logic [NUM_W-1:0]             mag;
	logic [NUM_W:0]               q_adj;
	logic [NUM_W:0]               p_sum;
	logic [PERIOD_BITS-1:0]       period_new;
	logic [1:0]                   pos_new;
	logic [1:0]                   pos_res;
	logic [PERIOD_BITS-1:0]       period_res;
	logic [31:0]                  period_wide;
	qee_pkg::out_t                res_d;

	qee_div #(
		.NUM_W(NUM_W),
		.DEN_W(qee_pkg::DEN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// tick counter and period seen by the arriving item
	assign period_eff  = was_q ? period_q : PERIOD_BITS'(start_q);
	assign wrap        = (cnt_q >= period_eff);
	assign upd         = head.run && wrap;
	assign period_take = head.run ? period_eff : period_q;

	// signed period error as sign and magnitude
	assign div_eff = (smooth_q == '0) ? qee_pkg::SMOOTH_W'(1) : smooth_q;
	assign t_ext   = NUM_W'(target_q);
	assign p_ext   = NUM_W'(period_q);
	assign neg     = (t_ext < p_ext);
	assign mag     = neg ? (p_ext - t_ext) : (t_ext - p_ext);

	// negative error rounds toward minus infinity
	assign q_adj      = {1'b0, div_quo} + (NUM_W + 1)'(neg_q && (div_rem != '0));
	assign p_sum      = neg_q ? ({1'b0, p_ext} - q_adj) : ({1'b0, p_ext} + q_adj);
	assign period_new = p_sum[PERIOD_BITS-1:0];

	assign pos_new = !step_en_q ? pos_q : (step_rev_q ? (pos_q - 2'd1) : (pos_q + 2'd1));
	assign pos_res    = ramp_done ? pos_new : pos_q;
	assign period_res = ramp_done ? period_new : period_take;
	assign period_wide = 32'(period_res);

	always_comb begin
		res_d.enc_a        = !pos_res[1];
		res_d.enc_b        = !(pos_res[1] ^ pos_res[0]);
		res_d.update_event = ramp_done;
		res_d.step_valid   = ramp_done && step_en_q;
		res_d.step_dir     = ramp_done && step_en_q && step_rev_q;
		res_d.period_now   = period_wide[15:0];
	end

	always_comb begin
		state_d      = state_q;
		take         = 1'b0;
		res_wr       = 1'b0;
		ramp_done    = 1'b0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			qee_pkg::ST_IDLE: begin
				if (head_valid && !res_valid_q) begin
					take = 1'b1;
					if (!upd) begin
						res_wr = 1'b1;
					end else if (head.duty == '0) begin
						state_d = qee_pkg::ST_PREP;
					end else begin
						div_start    = 1'b1;
						div_dividend = NUM_W'(qee_pkg::TARGET_NUM);
						div_divisor  = head.duty;
						state_d      = qee_pkg::ST_DIV_TARGET;
					end
				end
			end
			qee_pkg::ST_DIV_TARGET: begin
				if (div_done)
					state_d = qee_pkg::ST_PREP;
			end
			qee_pkg::ST_PREP: begin
				div_start    = 1'b1;
				div_dividend = mag;
				div_divisor  = qee_pkg::DEN_W'(div_eff);
				state_d      = qee_pkg::ST_DIV_RAMP;
			end
			qee_pkg::ST_DIV_RAMP: begin
				if (div_done) begin
					res_wr    = 1'b1;
					ramp_done = 1'b1;
					state_d   = qee_pkg::ST_IDLE;
				end
			end
			default: state_d = qee_pkg::ST_IDLE;
		endcase
	end

	assign head_take = take;
	assign empty     = !res_valid_q;
	assign result    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= qee_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q    <= qee_pkg::SMOOTH_RESET;
			start_q     <= qee_pkg::START_RESET;
			cnt_q       <= '0;
			period_q    <= PERIOD_BITS'(qee_pkg::START_RESET);
			pos_q       <= 2'd0;
			was_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we && (cfg_index == qee_pkg::CFG_SMOOTH))
				smooth_q <= cfg_data[qee_pkg::SMOOTH_W-1:0];
			if (cfg_we && (cfg_index == qee_pkg::CFG_START))
				start_q <= cfg_data;
			if (take) begin
				was_q <= head.run;
				if (head.run) begin
					period_q <= period_eff;
					cnt_q    <= wrap ? '0 : (cnt_q + PERIOD_BITS'(1));
				end
			end
			if (ramp_done) begin
				period_q <= period_new;
				pos_q    <= pos_new;
			end
			if (res_wr)
				res_valid_q <= 1'b1;
			else if (pop)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_wr)
			res_q <= res_d;
		if (take) begin
			target_q   <= qee_pkg::TARGET_AT_ZERO;
			step_en_q  <= head.step_en;
			step_rev_q <= head.step_rev;
		end else if ((state_q == qee_pkg::ST_DIV_TARGET) && div_done) begin
			target_q <= div_quo[qee_pkg::TARGET_W-1:0];
		end
		if (state_q == qee_pkg::ST_PREP)
			neg_q <= neg;
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("division started while divider busy");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !pop |=> res_valid_q && $stable(res_q))
		else $error("waiting result lost or changed");

	a_step_on_update: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (!res_q.step_valid || res_q.update_event))
		else $error("step issued without counter wrap");

endmodule

// ----- rtl/quadrature_encoder_emulator.sv -----
`timescale 1ns / 1ps
// Flow: an item is taken from the head of the 2-entry input queue only while no result waits;
//   a non-wrapping tick's result is registered as the tick is taken, while a wrap runs
//   ST_DIV_TARGET (skipped at duty 0), ST_PREP and ST_DIV_RAMP, W = max(PERIOD_BITS,12),
//   with one bit-serial divider run once or twice.
// A result must be popped before the next item is taken.
// Reset: asynchronous, active low; clears queue, counter, position, result valid; loads 4000, 16.

module quadrature_encoder_emulator #(
	parameter int PERIOD_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  qee_pkg::in_t              sample,
	output logic                      empty,
	input  logic                      pop,
	output qee_pkg::out_t             result,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [qee_pkg::CFG_W-1:0] cfg_data
);

	logic           head_valid;
	logic           head_take;
	qee_pkg::item_t head;

	qee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.head_valid(head_valid),
		.head      (head),
		.head_take (head_take)
	);

	qee_back #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.head_take (head_take),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int WRAP_LATENCY = 40;
	localparam int STALL_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	qee_pkg::in_t sample;
	logic empty;
	logic pop;
	qee_pkg::out_t result;
	logic cfg_we;
	qee_pkg::cfg_idx_t cfg_index;
	logic [qee_pkg::CFG_W-1:0] cfg_data;

	logic [qee_pkg::SMOOTH_W-1:0] div_reg;
	logic [15:0] start_reg;
	logic [15:0] tick_count;
	logic [15:0] period_val;
	logic [1:0] quad_pos;
	logic running;

	qee_pkg::out_t pending_results[$];
	int error_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;

	quadrature_encoder_emulator dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic qee_pkg::out_t encoder_tick(qee_pkg::in_t t);
		qee_pkg::out_t r;
		logic wrapped;
		int tgt;
		int dv;
		int diff;
		int q;
		wrapped = 1'b0;
		r = '0;
		if (t.run) begin
			if (!running)
				period_val = start_reg;
			if (tick_count >= period_val) begin
				tick_count = '0;
				wrapped = 1'b1;
			end else begin
				tick_count = tick_count + 16'd1;
			end
		end
		running = t.run;
		if (wrapped) begin
			if (t.duty == 16'd0)
				tgt = qee_pkg::TARGET_AT_ZERO;
			else
				tgt = qee_pkg::TARGET_NUM / t.duty;
			dv = (div_reg == '0) ? 1 : int'(div_reg);
			diff = tgt - int'(period_val);
			if (diff >= 0)
				q = diff / dv;
			else
				q = -((-diff + dv - 1) / dv);
			period_val = 16'(int'(period_val) + q);
			if (t.command == qee_pkg::CMD_CW) begin
				r.step_valid = 1'b1;
				quad_pos = quad_pos + 2'd1;
			end else if (t.command == qee_pkg::CMD_CCW) begin
				r.step_valid = 1'b1;
				r.step_dir = 1'b1;
				quad_pos = quad_pos - 2'd1;
			end
		end
		r.enc_a = (quad_pos <= 2'd1);
		r.enc_b = (quad_pos == 2'd0) || (quad_pos == 2'd3);
		r.update_event = wrapped;
		r.period_now = period_val;
		return r;
	endfunction

	function automatic qee_pkg::in_t random_tick();
		qee_pkg::in_t t;
		int pick;
		pick = $urandom_range(9);
		if (pick < 6)
			t.duty = 16'($urandom_range(300, 65535));
		else if (pick < 8)
			t.duty = 16'($urandom);
		else if (pick == 8)
			t.duty = 16'd0;
		else
			t.duty = 16'($urandom_range(1, 3000));
		t.command = 2'($urandom_range(3));
		t.run = ($urandom_range(15) != 0);
		return t;
	endfunction

	task automatic send_tick(qee_pkg::in_t t);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		sample <= t;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_results.push_back(encoder_tick(t));
		@(negedge clk);
	endtask

	task automatic tick(logic [15:0] duty, logic [1:0] command, logic run);
		qee_pkg::in_t t;
		t.duty = duty;
		t.command = command;
		t.run = run;
		send_tick(t);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (WRAP_LATENCY) @(negedge clk);
	endtask

	task automatic write_cfg(qee_pkg::cfg_idx_t idx, logic [qee_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == qee_pkg::CFG_SMOOTH)
			div_reg = val[qee_pkg::SMOOTH_W-1:0];
		else
			start_reg = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic test_directed_ticks();
		write_cfg(qee_pkg::CFG_SMOOTH, 16'd0);
		write_cfg(qee_pkg::CFG_START, 16'd3);
		tick(16'hFFFF, qee_pkg::CMD_CW, 1'b0);
		tick(16'h0000, qee_pkg::CMD_CW, 1'b1);
		tick(16'h0000, qee_pkg::CMD_CW, 1'b1);
		tick(16'h0000, qee_pkg::CMD_CW, 1'b1);
		tick(16'hFFFF, qee_pkg::CMD_CW, 1'b1);
		tick(16'hFFFF, qee_pkg::CMD_CCW, 1'b1);
		tick(16'hFFFF, qee_pkg::CMD_CCW, 1'b1);
		tick(16'hFFFF, qee_pkg::CMD_STOP, 1'b1);
		tick(16'hFFFF, CMD_UNUSED, 1'b1);
		tick(16'd1000, qee_pkg::CMD_CW, 1'b1);
		tick(16'd1, qee_pkg::CMD_CW, 1'b1);
		tick(16'h0000, qee_pkg::CMD_CCW, 1'b0);
		drain();
		write_cfg(qee_pkg::CFG_SMOOTH, 16'd256);
		write_cfg(qee_pkg::CFG_START, 16'hFFFF);
		tick(16'd2999, qee_pkg::CMD_CW, 1'b1);
		tick(16'h5555, qee_pkg::CMD_CCW, 1'b1);
		tick(16'hAAAA, qee_pkg::CMD_CW, 1'b1);
		tick(16'd3001, qee_pkg::CMD_CW, 1'b0);
		drain();
		write_cfg(qee_pkg::CFG_START, 16'd0);
		tick(16'd2999, qee_pkg::CMD_CW, 1'b1);
		tick(16'd1, qee_pkg::CMD_CCW, 1'b1);
		tick(16'hFFFF, qee_pkg::CMD_CCW, 1'b1);
		drain();
		write_cfg(qee_pkg::CFG_SMOOTH, 16'd511);
		tick(16'd0, qee_pkg::CMD_CW, 1'b1);
		tick(16'd3000, qee_pkg::CMD_CW, 1'b1);
		drain();
	endtask

	task automatic test_random_traffic(int send_idle, int recv_stall, int count);
		logic [qee_pkg::CFG_W-1:0] div_val;
		logic [qee_pkg::CFG_W-1:0] start_val;
		drain();
		idle_pct = send_idle;
		stall_pct = recv_stall;
		case ($urandom_range(4))
			0: div_val = 16'd1;
			1: div_val = 16'd2;
			2: div_val = 16'd256;
			3: div_val = 16'($urandom_range(1, 32));
			default: div_val = 16'($urandom_range(1, 511));
		endcase
		if ($urandom_range(5) == 0)
			start_val = 16'hFFFF;
		else
			start_val = 16'($urandom_range(0, 15));
		write_cfg(qee_pkg::CFG_SMOOTH, div_val);
		write_cfg(qee_pkg::CFG_START, start_val);
		repeat (count) send_tick(random_tick());
	endtask

	always @(negedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		qee_pkg::out_t want;
		if (pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result %h", result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (result.enc_a !== want.enc_a) begin
					$error("enc_a: expected %0d, got %0d", want.enc_a, result.enc_a);
					error_count++;
				end
				if (result.enc_b !== want.enc_b) begin
					$error("enc_b: expected %0d, got %0d", want.enc_b, result.enc_b);
					error_count++;
				end
				if (result.update_event !== want.update_event) begin
					$error("update_event: expected %0d, got %0d",
						want.update_event, result.update_event);
					error_count++;
				end
				if (result.step_valid !== want.step_valid) begin
					$error("step_valid: expected %0d, got %0d",
						want.step_valid, result.step_valid);
					error_count++;
				end
				if (result.step_dir !== want.step_dir) begin
					$error("step_dir: expected %0d, got %0d", want.step_dir, result.step_dir);
					error_count++;
				end
				if (result.period_now !== want.period_now) begin
					$error("period_now: expected %0d, got %0d",
						want.period_now, result.period_now);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = qee_pkg::CFG_SMOOTH;
		cfg_data = '0;
		div_reg = qee_pkg::SMOOTH_RESET;
		start_reg = qee_pkg::START_RESET;
		tick_count = '0;
		period_val = 16'(qee_pkg::TARGET_AT_ZERO);
		quad_pos = '0;
		running = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed_ticks();
		test_random_traffic(0, 0, 150);
		test_random_traffic(57, 0, 150);
		test_random_traffic(0, 57, 150);
		test_random_traffic(27, 27, 150);
		drain();
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
